@@ sv/feedback_rotation_quaternion_macros.svh @@
// Assertion macros shared by the balance feedback rotation block.
`ifndef FEEDBACK_ROTATION_QUATERNION_MACROS_SVH
`define FEEDBACK_ROTATION_QUATERNION_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FBRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FBRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fbrq_pkg.sv @@
// Shared types, constants and arithmetic helpers of the feedback rotation block.
package fbrq_pkg;

	localparam int unsigned MAX_TERMS_DEF = 3;
	localparam int unsigned FACTOR_LAT    = 22;

	localparam int unsigned IN_W    = 96;
	localparam int unsigned OUT_W   = 64;
	localparam int unsigned GAIN_W  = 32;
	localparam int unsigned AXES_W  = 60;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned COUNT_W = 2;

	localparam logic [IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] CFG_GAINS_BASE = 3'd1;
	localparam logic [IDX_W-1:0] CFG_AXES_BASE  = 3'd2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [18:0] PHASE_GAIN  = 19'd333772;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] ONE_Q30     = 32'd1073741824;

	localparam logic [31:0] RCP_42 = 32'((64'd1 << 32) / 42);
	localparam logic [31:0] RCP_56 = 32'((64'd1 << 32) / 56);
	localparam logic [31:0] RCP_20 = 32'((64'd1 << 32) / 20);
	localparam logic [31:0] RCP_30 = 32'((64'd1 << 32) / 30);
	localparam logic [31:0] RCP_6  = 32'((64'd1 << 32) / 6);
	localparam logic [31:0] RCP_12 = 32'((64'd1 << 32) / 12);

	typedef struct packed {
		logic signed [26:0] w;
		logic signed [26:0] x;
		logic signed [26:0] y;
		logic signed [26:0] z;
	} fquat_t;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} rquat_t;

	// Quotient estimate by reciprocal; it is exact or one below the true quotient.
	function automatic logic [31:0] div_est(input logic [31:0] u, input logic [31:0] rcp);
		logic [63:0] p;
		p = u * rcp;
		return p[63:32];
	endfunction

	function automatic logic [31:0] div_fix(input logic [31:0] u, input logic [31:0] q0,
		input logic [31:0] d);
		logic [31:0] rem;
		rem = u - q0 * d;
		return (rem >= d) ? q0 + 32'd1 : q0;
	endfunction

	function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[61:30];
	endfunction

endpackage

@@ sv/fbrq_factor.sv @@
// One feedback term: angle, half-angle sine and cosine, and factor quaternion.
module fbrq_factor #(
	parameter int unsigned EXTRA = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [fbrq_pkg::IN_W-1:0]         vec,
	input  logic [fbrq_pkg::GAIN_W-1:0]       gains,
	input  logic [fbrq_pkg::AXES_W-1:0]       axes,
	output fbrq_pkg::fquat_t                  f
);

	logic signed [9:0]  a [3];
	logic signed [9:0]  b [3];
	logic signed [15:0] cd;
	logic signed [15:0] cv;

	logic signed [15:0] d_s1 [3];
	logic signed [15:0] v_s1 [3];
	logic signed [25:0] pd_s2 [3];
	logic signed [25:0] pv_s2 [3];
	logic signed [27:0] dd_s3, dv_s3;
	logic signed [43:0] md_s4, mv_s4;
	logic signed [44:0] ang_s5;
	logic [42:0]        plo_s6;
	logic [23:0]        phi_s6;
	logic [1:0]         q_s7, q_s8, q_s9, q_s10, q_s11, q_s12, q_s13;
	logic [1:0]         q_s14, q_s15, q_s16, q_s17, q_s18, q_s19;
	logic signed [29:0] r_s7;
	logic signed [30:0] x_s8, x_s9, x_s10, x_s11, x_s12, x_s13, x_s14, x_s15, x_s16, x_s17;
	logic [31:0]        x2_s9, x2_s10, x2_s11, x2_s12, x2_s13, x2_s14, x2_s15, x2_s16;
	logic [31:0]        x2_s17;
	logic [31:0]        es_s10, ec_s10, ts_s11, tc_s11, ms_s12, mc_s12;
	logic [31:0]        es_s13, ec_s13, ms_s13, mc_s13, ts_s14, tc_s14;
	logic [31:0]        ms_s15, mc_s15, es_s16, ec_s16, ms_s16, mc_s16;
	logic [31:0]        ts_s17, tc_s17, mc_s18;
	logic signed [31:0] s_s18, s_s19, c_s19, sn_s20, cs_s20;
	logic signed [26:0] fw_s21;
	logic signed [41:0] pb_s21 [3];
	fbrq_pkg::fquat_t   f_s22;

	logic [47:0]        psum;
	logic [31:0]        phase;
	logic signed [61:0] xprod;
	logic signed [61:0] xsq;
	logic signed [63:0] sprod;
	logic signed [32:0] cw;
	logic signed [42:0] fr [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(axes[10*i +: 10]);
			b[i] = $signed(axes[30 + 10*i +: 10]);
		end
		cd = $signed(gains[31:16]);
		cv = $signed(gains[15:0]);
		psum  = {phi_s6, 24'd0} + {5'd0, plo_s6};
		phase = psum[47:16];
		xprod = r_s7 * $signed({1'b0, fbrq_pkg::HALF_PI_Q30});
		xsq   = x_s8 * x_s8;
		sprod = x_s17 * $signed({1'b0, ts_s17});
		cw    = {cs_s20[31], cs_s20} + 33'sd32;
		for (int i = 0; i < 3; i++) begin
			fr[i] = {pb_s21[i][41], pb_s21[i]} + 43'sd8192;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= $signed(vec[16*i +: 16]);
				v_s1[i]  <= $signed(vec[48 + 16*i +: 16]);
				pd_s2[i] <= d_s1[i] * a[i];
				pv_s2[i] <= v_s1[i] * a[i];
			end
			dd_s3  <= 28'(pd_s2[0]) + 28'(pd_s2[1]) + 28'(pd_s2[2]);
			dv_s3  <= 28'(pv_s2[0]) + 28'(pv_s2[1]) + 28'(pv_s2[2]);
			md_s4  <= cd * dd_s3;
			mv_s4  <= cv * dv_s3;
			ang_s5 <= 45'(md_s4) + 45'(mv_s4);
			plo_s6 <= ang_s5[23:0] * fbrq_pkg::PHASE_GAIN;
			phi_s6 <= 24'({{3{ang_s5[44]}}, ang_s5[44:24]} * {5'd0, fbrq_pkg::PHASE_GAIN});

			q_s7 <= phase[31:30] + {1'b0, phase[29]};
			r_s7 <= $signed(phase[29:0]);

			q_s8 <= q_s7;
			x_s8 <= xprod[60:30];

			q_s9  <= q_s8;
			x_s9  <= x_s8;
			x2_s9 <= {2'd0, xsq[59:30]};

			q_s10  <= q_s9;
			x_s10  <= x_s9;
			x2_s10 <= x2_s9;
			es_s10 <= fbrq_pkg::div_est(x2_s9, fbrq_pkg::RCP_42);
			ec_s10 <= fbrq_pkg::div_est(x2_s9, fbrq_pkg::RCP_56);

			q_s11  <= q_s10;
			x_s11  <= x_s10;
			x2_s11 <= x2_s10;
			ts_s11 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(x2_s10, es_s10, 32'd42);
			tc_s11 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(x2_s10, ec_s10, 32'd56);

			q_s12  <= q_s11;
			x_s12  <= x_s11;
			x2_s12 <= x2_s11;
			ms_s12 <= fbrq_pkg::mul_q30(x2_s11, ts_s11);
			mc_s12 <= fbrq_pkg::mul_q30(x2_s11, tc_s11);

			q_s13  <= q_s12;
			x_s13  <= x_s12;
			x2_s13 <= x2_s12;
			ms_s13 <= ms_s12;
			mc_s13 <= mc_s12;
			es_s13 <= fbrq_pkg::div_est(ms_s12, fbrq_pkg::RCP_20);
			ec_s13 <= fbrq_pkg::div_est(mc_s12, fbrq_pkg::RCP_30);

			q_s14  <= q_s13;
			x_s14  <= x_s13;
			x2_s14 <= x2_s13;
			ts_s14 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(ms_s13, es_s13, 32'd20);
			tc_s14 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(mc_s13, ec_s13, 32'd30);

			q_s15  <= q_s14;
			x_s15  <= x_s14;
			x2_s15 <= x2_s14;
			ms_s15 <= fbrq_pkg::mul_q30(x2_s14, ts_s14);
			mc_s15 <= fbrq_pkg::mul_q30(x2_s14, tc_s14);

			q_s16  <= q_s15;
			x_s16  <= x_s15;
			x2_s16 <= x2_s15;
			ms_s16 <= ms_s15;
			mc_s16 <= mc_s15;
			es_s16 <= fbrq_pkg::div_est(ms_s15, fbrq_pkg::RCP_6);
			ec_s16 <= fbrq_pkg::div_est(mc_s15, fbrq_pkg::RCP_12);

			q_s17  <= q_s16;
			x_s17  <= x_s16;
			x2_s17 <= x2_s16;
			ts_s17 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(ms_s16, es_s16, 32'd6);
			tc_s17 <= fbrq_pkg::ONE_Q30 - fbrq_pkg::div_fix(mc_s16, ec_s16, 32'd12);

			q_s18  <= q_s17;
			s_s18  <= sprod[61:30];
			mc_s18 <= fbrq_pkg::mul_q30(x2_s17, tc_s17);

			q_s19 <= q_s18;
			s_s19 <= s_s18;
			c_s19 <= $signed(fbrq_pkg::ONE_Q30 - {1'b0, mc_s18[31:1]});

			case (q_s19)
				fbrq_pkg::QUAD_0: begin
					cs_s20 <= c_s19;
					sn_s20 <= s_s19;
				end
				fbrq_pkg::QUAD_1: begin
					cs_s20 <= -s_s19;
					sn_s20 <= c_s19;
				end
				fbrq_pkg::QUAD_2: begin
					cs_s20 <= -c_s19;
					sn_s20 <= -s_s19;
				end
				default: begin
					cs_s20 <= s_s19;
					sn_s20 <= -c_s19;
				end
			endcase

			fw_s21 <= cw[32:6];
			for (int i = 0; i < 3; i++) begin
				pb_s21[i] <= sn_s20 * b[i];
			end

			f_s22.w <= fw_s21;
			f_s22.x <= fr[0][40:14];
			f_s22.y <= fr[1][40:14];
			f_s22.z <= fr[2][40:14];
		end
	end

	generate
		if (EXTRA == 0) begin : g_direct
			assign f = f_s22;
		end else begin : g_delay
			fbrq_pkg::fquat_t dly_q [EXTRA];
			always_ff @(posedge clk) begin
				if (en) begin
					dly_q[0] <= f_s22;
					for (int i = 1; i < int'(EXTRA); i++) begin
						dly_q[i] <= dly_q[i-1];
					end
				end
			end
			assign f = dly_q[EXTRA-1];
		end
	endgenerate

endmodule

@@ sv/feedback_rotation_quaternion.sv @@
// Top level of the balance feedback rotation block: registers, term chain, output.
//
//   channel  direction  fields
//   s_*      in         offset_x, offset_y, offset_z, vel_x, vel_y, vel_z
//   m_*      out        quat_w, quat_x, quat_y, quat_z
//   cfg_*    in         term_count, gains_k, axes_k
//
// One request enters per cycle unless the output stalls; it passes the 22-stage
// term factors, two stages per quaternion product and the output register.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset clears the valid bits and all configuration registers.
module feedback_rotation_quaternion #(
	parameter int unsigned MAX_TERMS = fbrq_pkg::MAX_TERMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// offset_x, offset_y, offset_z, vel_x, vel_y, vel_z
	input  logic [fbrq_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// quat_w, quat_x, quat_y, quat_z
	output logic [fbrq_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [fbrq_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fbrq_pkg::AXES_W-1:0]   cfg_data
);

	localparam int unsigned TOTAL = fbrq_pkg::FACTOR_LAT + 2 * MAX_TERMS + 1;

	logic [fbrq_pkg::COUNT_W-1:0] term_count_q;
	logic [fbrq_pkg::GAIN_W-1:0]  gains_q [MAX_TERMS];
	logic [fbrq_pkg::AXES_W-1:0]  axes_q [MAX_TERMS];
	logic [TOTAL-1:0]             vld_q;
	logic                         en;
	fbrq_pkg::fquat_t             lf [MAX_TERMS];
	fbrq_pkg::rquat_t             rq [MAX_TERMS+1];
	logic [fbrq_pkg::OUT_W-1:0]   tdata_q;
	logic                         w_ok;
	logic                         x_ok;

	function automatic logic signed [31:0] rnd24(input logic signed [60:0] v);
		logic signed [60:0] t;
		t = (v + (61'sd1 <<< 23)) >>> 24;
		return t[31:0];
	endfunction

	function automatic logic [15:0] sat14(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = ($signed({v[31], v}) + 33'sd512) >>> 10;
		if (t > 33'sd16384) begin
			return 16'sd16384;
		end else if (t < -33'sd16384) begin
			return -16'sd16384;
		end else begin
			return t[15:0];
		end
	endfunction

	assign en       = !vld_q[TOTAL-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[TOTAL-1];
	assign m_tdata  = tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
			for (int k = 0; k < int'(MAX_TERMS); k++) begin
				gains_q[k] <= '0;
				axes_q[k]  <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == fbrq_pkg::CFG_TERM_COUNT) begin
				term_count_q <= cfg_data[fbrq_pkg::COUNT_W-1:0];
			end
			for (int k = 0; k < int'(MAX_TERMS); k++) begin
				if (cfg_index == fbrq_pkg::CFG_GAINS_BASE + 3'(2 * k)) begin
					gains_q[k] <= cfg_data[fbrq_pkg::GAIN_W-1:0];
				end
				if (cfg_index == fbrq_pkg::CFG_AXES_BASE + 3'(2 * k)) begin
					axes_q[k] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL-2:0], s_tvalid};
		end
	end

	assign rq[0] = '{w: 32'sd16777216, x: 32'sd0, y: 32'sd0, z: 32'sd0};

	genvar k;
	generate
		for (k = 0; k < MAX_TERMS; k++) begin : g_term
			logic signed [26:0] fa [4];
			logic signed [31:0] ra [4];
			logic signed [58:0] p_s1 [4][4];
			fbrq_pkg::rquat_t   rp_s1;
			logic signed [60:0] sw, sx, sy, sz;
			fbrq_pkg::rquat_t   n;
			logic               use_term;

			fbrq_factor #(
				.EXTRA(2 * k)
			) u_factor (
				.clk  (clk),
				.en   (en),
				.vec  (s_tdata),
				.gains(gains_q[k]),
				.axes (axes_q[k]),
				.f    (lf[k])
			);

			assign fa[0] = lf[k].w;
			assign fa[1] = lf[k].x;
			assign fa[2] = lf[k].y;
			assign fa[3] = lf[k].z;
			assign ra[0] = rq[k].w;
			assign ra[1] = rq[k].x;
			assign ra[2] = rq[k].y;
			assign ra[3] = rq[k].z;
			assign use_term = (2'(k) < term_count_q);

			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 4; i++) begin
						for (int j = 0; j < 4; j++) begin
							p_s1[i][j] <= fa[i] * ra[j];
						end
					end
					rp_s1 <= rq[k];
				end
			end

			always_comb begin
				sw = 61'(p_s1[0][0]) - 61'(p_s1[1][1]) - 61'(p_s1[2][2]) - 61'(p_s1[3][3]);
				sx = 61'(p_s1[0][1]) + 61'(p_s1[1][0]) + 61'(p_s1[2][3]) - 61'(p_s1[3][2]);
				sy = 61'(p_s1[0][2]) - 61'(p_s1[1][3]) + 61'(p_s1[2][0]) + 61'(p_s1[3][1]);
				sz = 61'(p_s1[0][3]) + 61'(p_s1[1][2]) - 61'(p_s1[2][1]) + 61'(p_s1[3][0]);
				n.w = rnd24(sw);
				n.x = rnd24(sx);
				n.y = rnd24(sy);
				n.z = rnd24(sz);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rq[k+1] <= use_term ? n : rp_s1;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= {sat14(rq[MAX_TERMS].z), sat14(rq[MAX_TERMS].y),
				sat14(rq[MAX_TERMS].x), sat14(rq[MAX_TERMS].w)};
		end
	end

	assign w_ok = ($signed(m_tdata[15:0]) <= 16'sd16384) &&
		($signed(m_tdata[15:0]) >= -16'sd16384);
	assign x_ok = ($signed(m_tdata[31:16]) <= 16'sd16384) &&
		($signed(m_tdata[31:16]) >= -16'sd16384);

	`include "feedback_rotation_quaternion_macros.svh"

	`FBRQ_ASSERT_NOW(a_ready_follows_output, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")
	`FBRQ_ASSERT_NEXT(a_frozen_when_stalled, !s_tready, $stable(vld_q), "pipeline moved in a stall")
	`FBRQ_ASSERT_NOW(a_w_in_range, m_tvalid, w_ok, "quat_w out of range")
	`FBRQ_ASSERT_NOW(a_x_in_range, m_tvalid, x_ok, "quat_x out of range")

endmodule
